### rtl/core/assert_macros.svh
// assertion macros used by the kmeans assign/update core
// no dependencies; define SYNTHESIS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/core/kmeans_pkg.sv
// shared types and constants for the kmeans assign/update core
// no dependencies
package kmeans_pkg;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_LANES = 4;
    localparam int DEF_COUNT_BITS = 24;
    localparam int ATTR_W = 16;
    localparam int SUM_W = 40;
    localparam int DIST_W = 34;
    localparam int PASS_W = 16;
    localparam int IN_ATTRS = 4;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ASSIGN = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;

    localparam logic REG_CLUSTERS = 1'b0;
    localparam logic REG_ATTRS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } t_state;

    // lane control issued by the sequencer
    typedef struct packed {
        logic div_start;
        logic lane_clear;
    } t_lane_ctl;
endpackage

### rtl/core/kmeans_divider.sv
// restoring divider: signed sum over unsigned count, truncated, saturated to 16 bits
// depends on kmeans_pkg; one quotient bit per cycle
module kmeans_divider
    import kmeans_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_num,
    input  logic [COUNT_BITS-1:0]    i_den,
    output logic                     o_done,
    output logic signed [ATTR_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_q, n_q;
    logic [COUNT_BITS:0] r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic r_neg, r_busy, r_zero;
    logic [CNT_W-1:0] r_cnt;
    logic [COUNT_BITS:0] w_trial;
    logic [SUM_W-1:0] w_mag;
    logic [SUM_W:0] w_sq;

    assign w_mag = i_num[SUM_W-1] ? SUM_W'(-i_num) : SUM_W'(i_num);
    assign w_trial = {r_rem[COUNT_BITS-1:0], r_q[SUM_W-1]};

    // one shift-subtract step
    always_comb begin
        n_q = {r_q[SUM_W-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[SUM_W-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    // sign and saturation
    assign o_done = !r_busy;
    assign w_sq = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
    always_comb begin
        if (r_zero) o_quot = '0;
        else if (!r_neg && r_q > SUM_W'(32767)) o_quot = 16'sh7fff;
        else if (r_neg && r_q > SUM_W'(32768)) o_quot = 16'sh8000;
        else o_quot = w_sq[ATTR_W-1:0];
    end
endmodule

### rtl/core/kmeans_lane.sv
// one attribute lane: centroid and sum registers, squared difference, mean divider
// depends on kmeans_pkg and kmeans_divider
module kmeans_lane
    import kmeans_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int CW = $clog2(MAX_CLUSTERS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic                     i_en,
    input  logic signed [ATTR_W-1:0] i_attr,
    input  logic                     i_load,
    input  logic [CW-1:0]            i_load_slot,
    input  logic [CW-1:0]            i_sel,
    input  logic                     i_acc,
    input  logic [COUNT_BITS-1:0]    i_count,
    input  logic                     i_mean_wr,
    output logic [DIST_W-1:0]        o_sq,
    output logic                     o_div_done,
    output logic signed [ATTR_W-1:0] o_mean
);
    logic signed [ATTR_W-1:0] r_cent [MAX_CLUSTERS];
    logic signed [SUM_W-1:0] r_sum [MAX_CLUSTERS];
    logic signed [ATTR_W:0] w_diff;
    logic signed [2*ATTR_W+1:0] w_prod;
    logic signed [SUM_W:0] w_acc;
    logic signed [SUM_W-1:0] w_sat;
    logic signed [ATTR_W-1:0] w_quot;

    // squared difference against the selected centroid
    assign w_diff = {i_attr[ATTR_W-1], i_attr} - {r_cent[i_sel][ATTR_W-1], r_cent[i_sel]};
    assign w_prod = w_diff * w_diff;
    assign o_sq = i_en ? DIST_W'($unsigned(w_prod)) : '0;

    // saturating accumulate
    assign w_acc = {r_sum[i_sel][SUM_W-1], r_sum[i_sel]}
                 + (SUM_W+1)'(i_attr);
    always_comb begin
        if (w_acc[SUM_W] != w_acc[SUM_W-1])
            w_sat = w_acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else w_sat = w_acc[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                r_cent[c] <= '0;
                r_sum[c] <= '0;
            end
        end else begin
            if (i_load) r_cent[i_load_slot] <= i_attr;
            if (i_mean_wr && i_en) r_cent[i_sel] <= w_quot;
            if (i_ctl.lane_clear) begin
                for (int c = 0; c < MAX_CLUSTERS; c++) r_sum[c] <= '0;
            end else if (i_acc && i_en) begin
                r_sum[i_sel] <= w_sat;
            end
        end
    end

    kmeans_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_sum[i_sel]),
        .i_den   (i_count),
        .o_done  (o_div_done),
        .o_quot  (w_quot)
    );

    // new mean straight from the divider, as it is written back
    assign o_mean = i_en ? w_quot : '0;
endmodule

### rtl/core/kmeans_assign_update.sv
// kmeans assign/update core: mode 0 load and ignored words are taken every cycle while no
// result is pending. mode 1 assign: the word is compared against each centroid in use
// (one centroid compared per cycle, lanes in parallel), then the result is registered; the
// next word is taken once the result is accepted. mode 2 update, per cluster: dividers start,
// the mean is written back as the result is registered, the next cluster starts on accept.
// synchronous active-low reset clears centroids, sums, counts, flags and pass count
module kmeans_assign_update
    import kmeans_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int LANES = DEF_LANES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], centroid_slot[4:2], attr_0..attr_3[68:5], prev_cluster[72:69], zero pad
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // nearest[2:0], moved[3], best_distance[37:4], mean_0..mean_3[101:38],
    // pass_changed[102], pass_count[118:103], zero pad
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int KW = $clog2(MAX_CLUSTERS + 1);
    localparam int LW = $clog2(LANES + 1);

    logic [3:0] r_k_reg;
    logic [2:0] r_a_reg;
    logic [KW-1:0] w_k;
    logic [LW-1:0] w_a;
    t_state r_state, n_state;
    logic [79:0] r_in;
    logic [CW-1:0] r_c;
    logic [DIST_W-1:0] r_best_d;
    logic [CW-1:0] r_best;
    logic [COUNT_BITS-1:0] r_count [MAX_CLUSTERS];
    logic r_moved_any;
    logic [PASS_W-1:0] r_pass;
    logic r_ov;
    logic [119:0] r_odata;
    logic r_olast;
    logic r_div_go, n_div_go;
    logic [DIST_W-1:0] w_sq [LANES];
    logic [DIST_W-1:0] w_dist;
    logic [LANES-1:0] w_done;
    logic signed [ATTR_W-1:0] w_mean [LANES];
    logic [LANES-1:0] w_en;
    logic [CW-1:0] w_sel;
    logic w_acc, w_full, w_mv, w_cfg_wr, w_take, w_last_c;
    t_lane_ctl w_ctl;
    logic [63:0] w_means;

    // configuration port
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_reg <= 4'd2;
            r_a_reg <= 3'd4;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_CLUSTERS) r_k_reg <= pwdata[3:0];
            else r_a_reg <= pwdata[2:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CLUSTERS) prdata[3:0] = r_k_reg;
        else prdata[2:0] = r_a_reg;
    end
    always_comb begin
        if (r_k_reg < 4'd2) w_k = KW'(2);
        else if (32'(r_k_reg) > MAX_CLUSTERS) w_k = KW'(MAX_CLUSTERS);
        else w_k = KW'(r_k_reg);
        if (r_a_reg < 3'd1) w_a = LW'(1);
        else if (32'(r_a_reg) > LANES) w_a = LW'(LANES);
        else w_a = LW'(r_a_reg);
    end

    assign w_take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ov;
    assign w_last_c = ({1'b0, r_c} == KW'(w_k - 1'b1));
    assign w_sel = (r_state == ST_ACC) ? r_best : r_c;

    // lanes side by side
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [ATTR_W-1:0] w_attr;
        if (l < IN_ATTRS) begin : g_in
            assign w_attr = r_in[5 + ATTR_W*l +: ATTR_W];
        end else begin : g_zero
            assign w_attr = '0;
        end
        assign w_en[l] = (LW'(l) < w_a);
        kmeans_lane #(.MAX_CLUSTERS(MAX_CLUSTERS), .COUNT_BITS(COUNT_BITS)) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_en        (w_en[l]),
            .i_attr      ((l < IN_ATTRS && w_take) ?
                          s_axis_tdata[5 + ATTR_W*(l % IN_ATTRS) +: ATTR_W] : w_attr),
            .i_load      (w_take && s_axis_tdata[1:0] == MODE_LOAD
                          && 32'(s_axis_tdata[4:2]) < MAX_CLUSTERS),
            .i_load_slot (CW'(s_axis_tdata[4:2])),
            .i_sel       (w_sel),
            .i_acc       (w_acc),
            .i_count     (r_count[w_sel]),
            .i_mean_wr   (r_state == ST_DIV && w_done[0] && !w_ctl.div_start),
            .o_sq        (w_sq[l]),
            .o_div_done  (w_done[l]),
            .o_mean      (w_mean[l])
        );
    end

    // merge: sum of lane squares
    always_comb begin
        w_dist = '0;
        for (int l = 0; l < LANES; l++) w_dist = w_dist + w_sq[l];
    end

    assign w_full = &r_count[r_best];
    assign w_acc = (r_state == ST_ACC) && !w_full;
    assign w_mv = ({1'b0, r_best} != r_in[72:69]) || (r_in[72:69] > 4'(MAX_CLUSTERS - 1));

    // divider start: on an update word and between clusters
    assign n_div_go = (w_take && s_axis_tdata[1:0] == MODE_UPDATE)
                      || (r_state == ST_EMIT && !r_ov && r_in[1:0] == MODE_UPDATE
                          && !w_last_c);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_take) begin
                if (s_axis_tdata[1:0] == MODE_ASSIGN) n_state = ST_SCAN;
                else if (s_axis_tdata[1:0] == MODE_UPDATE) n_state = ST_DIV;
            end
            ST_SCAN: if (w_last_c) n_state = ST_ACC;
            ST_ACC:  n_state = ST_EMIT;
            ST_DIV:  if (w_done[0] && !r_div_go) n_state = ST_EMIT;
            ST_EMIT: if (!r_ov) n_state = (r_in[1:0] == MODE_UPDATE && !w_last_c)
                                          ? ST_DIV : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // lane control outputs
    always_comb begin
        w_ctl.div_start = (r_state == ST_DIV) && r_div_go;
        w_ctl.lane_clear = (r_state == ST_EMIT) && !r_ov
                           && r_in[1:0] == MODE_UPDATE && w_last_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_c <= '0;
            r_ov <= 1'b0;
            r_moved_any <= 1'b0;
            r_pass <= '0;
            r_div_go <= 1'b0;
            for (int c = 0; c < MAX_CLUSTERS; c++) r_count[c] <= '0;
        end else begin
            r_state <= n_state;
            r_div_go <= n_div_go;
            if (m_axis_tvalid && m_axis_tready) r_ov <= 1'b0;
            if (w_take) begin
                r_in <= s_axis_tdata;
                r_c <= '0;
                if (s_axis_tdata[1:0] == MODE_UPDATE) r_pass <= r_pass + 1'b1;
            end
            // scan: keep first minimum
            if (r_state == ST_SCAN) begin
                if (r_c == '0 || w_dist < r_best_d) begin
                    r_best_d <= w_dist;
                    r_best <= r_c;
                end
                if (!w_last_c) r_c <= r_c + 1'b1;
            end
            if (r_state == ST_ACC) begin
                if (w_acc) r_count[r_best] <= r_count[r_best] + 1'b1;
                r_ov <= 1'b1;
                r_olast <= 1'b1;
                r_odata <= {1'b0, r_pass, r_moved_any | w_mv, 64'd0,
                            r_best_d, w_mv, 3'(r_best)};
                if (w_mv) r_moved_any <= 1'b1;
            end
            if (r_state == ST_DIV && w_done[0] && !r_div_go && !w_ctl.div_start) begin
                r_ov <= 1'b1;
                r_olast <= w_last_c;
                r_odata <= {1'b0, r_pass, r_moved_any, w_means, 34'd0, 1'b0, 3'(r_c)};
            end
            if (r_state == ST_EMIT && !r_ov && r_in[1:0] == MODE_UPDATE) begin
                if (w_last_c) begin
                    r_moved_any <= 1'b0;
                    for (int c = 0; c < MAX_CLUSTERS; c++) r_count[c] <= '0;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
        end
    end

    // mean word taken from the lane dividers as they write back
    always_comb begin
        w_means = '0;
        for (int l = 0; l < LANES && l < IN_ATTRS; l++)
            w_means[ATTR_W*l +: ATTR_W] = w_mean[l];
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_odata;
    assign m_axis_tlast = r_olast;

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == ST_IDLE, "ready while busy")
    `ASSERT_IMPLIES(a_scan_range, i_clk, i_rst_n, r_state == ST_SCAN, {1'b0, r_c} < w_k, "scan index out of range")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

### tb/kmeans_assign_update_test.sv
// self-checking testbench for the kmeans assign/update core: drives points over the
// input stream, writes both registers over apb and compares every result word with a model
// depends on kmeans_pkg and kmeans_assign_update
module kmeans_assign_update_test;
    import kmeans_pkg::*;

    localparam int NCL = 8;
    localparam int NLN = 4;
    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -64'sd549755813888;
    localparam longint CNT_MAX = (64'd1 << 24) - 1;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] pass_count;
        logic        pass_changed;
        logic [63:0] means;
        logic [33:0] best_distance;
        logic        moved;
        logic [2:0]  nearest;
        logic        last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    kmeans_assign_update dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state
    int     centroid [NCL][NLN];
    longint sums [NCL][NLN];
    longint counts [NCL];
    bit     moved_so_far;
    int     passes;
    int     k_regval, a_regval;

    t_result expected_words[$];
    int  send_idle_pct, recv_idle_pct;
    int  errors = 0;
    int  words_checked = 0;
    int  points_sent, passes_run;
    int  quiet_cycles = 0;

    function automatic int clusters_now();
        return k_regval < 2 ? 2 : (k_regval > NCL ? NCL : k_regval);
    endfunction

    function automatic int lanes_now();
        return a_regval < 1 ? 1 : (a_regval > NLN ? NLN : a_regval);
    endfunction

    // model of one accepted word
    task automatic predict_item(input logic [79:0] w);
        logic [1:0] mode;
        int k, a, best, prev, v;
        longint bd, d, df, s;
        t_result r;
        mode = w[1:0];
        k = clusters_now();
        a = lanes_now();
        if (mode == MODE_LOAD) begin
            for (int l = 0; l < NLN; l++)
                centroid[w[4:2]][l] = int'($signed(w[5 + 16*l +: 16]));
        end else if (mode == MODE_ASSIGN) begin
            best = 0;
            bd = 0;
            prev = int'(w[72:69]);
            for (int c = 0; c < k; c++) begin
                d = 0;
                for (int l = 0; l < a; l++) begin
                    v = int'($signed(w[5 + 16*l +: 16]));
                    df = longint'(v) - longint'(centroid[c][l]);
                    d += df * df;
                end
                if (c == 0 || d < bd) begin
                    bd = d;
                    best = c;
                end
            end
            if (best != prev) moved_so_far = 1'b1;
            if (counts[best] < CNT_MAX) begin
                counts[best]++;
                for (int l = 0; l < a; l++) begin
                    v = int'($signed(w[5 + 16*l +: 16]));
                    s = sums[best][l] + longint'(v);
                    if (s > SUM_HI) s = SUM_HI;
                    if (s < SUM_LO) s = SUM_LO;
                    sums[best][l] = s;
                end
            end
            r = '0;
            r.nearest = 3'(best);
            r.moved = (best != prev);
            r.best_distance = bd[33:0];
            r.pass_changed = moved_so_far;
            r.pass_count = 16'(passes);
            r.last = 1'b1;
            expected_words.push_back(r);
        end else if (mode == MODE_UPDATE) begin
            passes = (passes + 1) & 32'hffff;
            for (int c = 0; c < k; c++) begin
                r = '0;
                for (int l = 0; l < a; l++) begin
                    s = 0;
                    if (counts[c] != 0) begin
                        s = sums[c][l] / counts[c];
                        if (s > 32767) s = 32767;
                        if (s < -32768) s = -32768;
                    end
                    centroid[c][l] = int'(s);
                    r.means[16*l +: 16] = s[15:0];
                end
                r.nearest = 3'(c);
                r.pass_changed = moved_so_far;
                r.pass_count = 16'(passes);
                r.last = (c + 1 == k);
                expected_words.push_back(r);
            end
            for (int c = 0; c < NCL; c++) begin
                counts[c] = 0;
                for (int l = 0; l < NLN; l++) sums[c][l] = 0;
            end
            moved_so_far = 1'b0;
        end
    endtask

    // send one word on the input stream, with random gaps before it
    task automatic send_word(input logic [79:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= w;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(w);
        if (w[1:0] == MODE_ASSIGN) points_sent++;
        if (w[1:0] == MODE_UPDATE) passes_run++;
        @(negedge i_clk);
    endtask

    function automatic logic [79:0] make_word(input logic [1:0] mode, input logic [2:0] slot,
                                              input logic [63:0] attrs, input logic [3:0] prev);
        return {7'd0, prev, attrs, slot, mode};
    endfunction

    function automatic logic [63:0] rand_attrs();
        return {$urandom, $urandom};
    endfunction

    // attributes clustered near a few centers so points spread over clusters
    function automatic logic [63:0] near_attrs(input int spread);
        logic [63:0] v;
        int base;
        base = (int'($urandom_range(3)) - 2) * 4000;
        for (int l = 0; l < NLN; l++)
            v[16*l +: 16] = 16'(base + int'($urandom_range(2*spread)) - spread);
        return v;
    endfunction

    // wait for idle, then write one register
    task automatic write_reg(input logic idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_CLUSTERS) k_regval = int'(val[3:0]);
        else a_regval = int'(val[2:0]);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.nearest = m_axis_tdata[2:0];
            got.moved = m_axis_tdata[3];
            got.best_distance = m_axis_tdata[37:4];
            got.means = m_axis_tdata[101:38];
            got.pass_changed = m_axis_tdata[102];
            got.pass_count = m_axis_tdata[118:103];
            got.last = m_axis_tlast;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (got.nearest !== want.nearest || got.moved !== want.moved
                    || got.best_distance !== want.best_distance
                    || got.means !== want.means || got.pass_changed !== want.pass_changed
                    || got.pass_count !== want.pass_count || got.last !== want.last
                    || m_axis_tdata[119] !== 1'b0) begin
                    $display("%0t: mismatch, expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on handshakes
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** kmeans_assign_update: FAILED **");
            $finish;
        end
    end

    task automatic test_load_and_extremes();
        send_word(make_word(MODE_ASSIGN, 3'd0, 64'd0, 4'd8));
        send_word(make_word(MODE_LOAD, 3'd0, {4{16'h8000}}, 4'd0));
        send_word(make_word(MODE_LOAD, 3'd1, {4{16'h7fff}}, 4'd0));
        send_word(make_word(MODE_ASSIGN, 3'd0, {4{16'h7fff}}, 4'd8));
        send_word(make_word(MODE_ASSIGN, 3'd0, {4{16'h8000}}, 4'd0));
        send_word(make_word(MODE_ASSIGN, 3'd0, {4{16'h7fff}}, 4'd1));
        send_word(make_word(MODE_ASSIGN, 3'd0, {4{16'h8000}}, 4'd15));
        // near-equal distance: the point is one step closer to cluster 0 than to cluster 1
        send_word(make_word(MODE_ASSIGN, 3'd0, {4{16'hffff}}, 4'd0));
        // mode 3 ignored
        send_word(make_word(2'd3, 3'd7, rand_attrs(), 4'd0));
        send_word(make_word(MODE_LOAD, 3'd7, rand_attrs(), 4'd0));
        send_word(make_word(MODE_UPDATE, 3'd0, 64'd0, 4'd0));
        // pass with no points: empty clusters go to zero
        send_word(make_word(MODE_UPDATE, 3'd0, 64'd0, 4'd0));
    endtask

    task automatic test_register_range();
        logic [31:0] kv[6] = '{0, 1, 15, 8, 5, 2};
        logic [31:0] av[6] = '{0, 7, 1, 4, 3, 2};
        for (int i = 0; i < 6; i++) begin
            write_reg(REG_CLUSTERS, kv[i]);
            write_reg(REG_ATTRS, av[i]);
            for (int c = 0; c < NCL; c++)
                send_word(make_word(MODE_LOAD, 3'(c), near_attrs(3000), 4'd0));
            repeat (5) send_word(make_word(MODE_ASSIGN, 3'd0, near_attrs(500),
                                           4'($urandom_range(8))));
            send_word(make_word(MODE_UPDATE, 3'd0, rand_attrs(), 4'd0));
        end
    endtask

    // well-formed passes with random content plus some noise
    task automatic test_random_passes(input int n_points);
        int sent;
        sent = 0;
        while (sent < n_points) begin
            if ($urandom_range(9) == 0) begin
                write_reg(REG_CLUSTERS, $urandom_range(15));
                write_reg(REG_ATTRS, $urandom_range(7));
            end
            for (int c = 0; c < NCL; c++)
                if ($urandom_range(3) != 0)
                    send_word(make_word(MODE_LOAD, 3'(c),
                        $urandom_range(4) == 0 ? rand_attrs() : near_attrs(2000), 4'd0));
            for (int p = $urandom_range(12, 3); p > 0; p--) begin
                send_word(make_word($urandom_range(19) == 0 ? 2'd3 : MODE_ASSIGN,
                    3'($urandom), $urandom_range(3) == 0 ? rand_attrs() : near_attrs(800),
                    4'($urandom_range(15))));
                sent++;
            end
            send_word(make_word(MODE_UPDATE, 3'($urandom), rand_attrs(), 4'($urandom)));
        end
    endtask

    initial begin
        foreach (centroid[c, l]) begin
            centroid[c][l] = 0;
            sums[c][l] = 0;
        end
        foreach (counts[c]) counts[c] = 0;
        moved_so_far = 0;
        passes = 0;
        k_regval = 2;
        a_regval = 4;
        points_sent = 0;
        passes_run = 0;
        send_idle_pct = 29;
        recv_idle_pct = 86;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_load_and_extremes();
        test_register_range();
        test_random_passes(50);
        send_idle_pct = 86;
        recv_idle_pct = 29;
        test_random_passes(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_passes(45);

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        $display("covered %0d points over %0d passes, %0d result words checked",
                 points_sent, passes_run, words_checked);
        if (errors == 0) begin
            $display("** kmeans_assign_update: PASSED **");
        end else begin
            $display("** kmeans_assign_update: FAILED **");
        end
        $finish;
    end
endmodule
